/* hw/rtl/sm83x_pkg.sv */
package sm83x_pkg;

    localparam int DEF_ADDR_BITS = 16;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_EXEC  = 2'd2,
        ACT_NONE  = 2'd3
    } t_act;

    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_UNSUP = 1'b1;

    typedef struct packed {
        t_act        action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [7:0]  read_data;
        logic [15:0] pc_value;
        logic [7:0]  acc_value;
        logic [3:0]  flag_bits;
        logic [15:0] sp_value;
    } t_res;

    // single memory port command
    typedef struct packed {
        logic        we;
        logic        re;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_cmd;

    // decoded opcode properties
    typedef struct packed {
        logic       ok;
        logic [1:0] n_imm;
        logic       rd1;
        logic       rd2;
        logic       push;
    } t_dec;

    // operand codes (B C D E H L (HL) A) and pair codes
    localparam logic [2:0] C8_B   = 3'd0;
    localparam logic [2:0] C8_C   = 3'd1;
    localparam logic [2:0] C8_D   = 3'd2;
    localparam logic [2:0] C8_E   = 3'd3;
    localparam logic [2:0] C8_H   = 3'd4;
    localparam logic [2:0] C8_L   = 3'd5;
    localparam logic [2:0] C8_MEM = 3'd6;
    localparam logic [2:0] C8_A   = 3'd7;
    localparam logic [1:0] RR_BC  = 2'd0;
    localparam logic [1:0] RR_DE  = 2'd1;
    localparam logic [1:0] RR_HL  = 2'd2;
    localparam logic [1:0] RR_SP  = 2'd3;

    localparam logic [7:0] MASK_R8    = 8'hC7;
    localparam logic [7:0] PAT_INC8   = 8'h04;
    localparam logic [7:0] PAT_DEC8   = 8'h05;
    localparam logic [7:0] MASK_RR    = 8'hCF;
    localparam logic [7:0] PAT_INC16  = 8'h03;
    localparam logic [7:0] PAT_DEC16  = 8'h0B;
    localparam logic [7:0] PAT_LD16   = 8'h01;
    localparam logic [7:0] OP_XOR_LO  = 8'hA8;
    localparam logic [7:0] OP_OR_LO   = 8'hB0;
    localparam logic [7:0] OP_OR_HI   = 8'hB7;
    localparam logic [7:0] OP_LDAR_LO = 8'h78;
    localparam logic [7:0] OP_LDAR_HI = 8'h7D;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_LD_B_B   = 8'h40;
    localparam logic [7:0] OP_LD_B_N   = 8'h06;
    localparam logic [7:0] OP_LD_C_N   = 8'h0E;
    localparam logic [7:0] OP_LD_E_N   = 8'h1E;
    localparam logic [7:0] OP_LD_L_N   = 8'h2E;
    localparam logic [7:0] OP_LD_A_N   = 8'h3E;
    localparam logic [7:0] OP_LD_M_N   = 8'h36;
    localparam logic [7:0] OP_LDI_HL_A = 8'h22;
    localparam logic [7:0] OP_LDD_HL_A = 8'h32;
    localparam logic [7:0] OP_LD_HL_A  = 8'h77;
    localparam logic [7:0] OP_LD_HL_B  = 8'h70;
    localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
    localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
    localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
    localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
    localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
    localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
    localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
    localparam logic [7:0] OP_LD_C_A   = 8'h4F;
    localparam logic [7:0] OP_LD_D_B   = 8'h50;
    localparam logic [7:0] OP_LD_H_B   = 8'h60;
    localparam logic [7:0] OP_JR       = 8'h18;
    localparam logic [7:0] OP_JR_NZ    = 8'h20;
    localparam logic [7:0] OP_JR_Z     = 8'h28;
    localparam logic [7:0] OP_JR_C     = 8'h38;
    localparam logic [7:0] OP_CP_N     = 8'hFE;
    localparam logic [7:0] OP_RLCA     = 8'h07;
    localparam logic [7:0] OP_RLA      = 8'h17;
    localparam logic [7:0] OP_JP       = 8'hC3;
    localparam logic [7:0] OP_CALL     = 8'hCD;
    localparam logic [7:0] OP_RET      = 8'hC9;
    localparam logic [7:0] OP_RST38    = 8'hFF;
    localparam logic [7:0] OP_DI       = 8'hF3;
    localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
    localparam logic [7:0] OP_PUSH_DE  = 8'hD5;
    localparam logic [7:0] OP_PUSH_HL  = 8'hE5;
    localparam logic [7:0] OP_PUSH_AF  = 8'hF5;
    localparam logic [7:0] OP_POP_BC   = 8'hC1;
    localparam logic [7:0] OP_POP_DE   = 8'hD1;
    localparam logic [7:0] OP_POP_HL   = 8'hE1;
    localparam logic [7:0] OP_POP_AF   = 8'hF1;

    localparam logic [15:0] RST_VEC   = 16'h0038;
    localparam logic [7:0]  HIGH_PAGE = 8'hFF;

    function automatic t_dec f_dec(input logic [7:0] op);
        t_dec d;
        d = '0;
        d.ok = 1'b1;
        if ((op & MASK_R8) == PAT_INC8 || (op & MASK_R8) == PAT_DEC8) begin
            d.rd1 = (op[5:3] == C8_MEM);
        end else if ((op & MASK_RR) == PAT_INC16 || (op & MASK_RR) == PAT_DEC16) begin
            d.ok = 1'b1;
        end else if ((op & MASK_RR) == PAT_LD16) begin
            d.n_imm = 2'd2;
        end else if (op >= OP_XOR_LO && op <= OP_OR_HI) begin
            d.rd1 = (op[2:0] == C8_MEM);
        end else if (op >= OP_LDAR_LO && op <= OP_LDAR_HI) begin
            d.ok = 1'b1;
        end else begin
            unique case (op)
                OP_NOP, OP_LD_B_B, OP_DI, OP_LDI_HL_A, OP_LDD_HL_A, OP_LD_HL_A,
                OP_LD_HL_B, OP_LDH_C_A, OP_LD_C_A, OP_LD_D_B, OP_LD_H_B,
                OP_RLCA, OP_RLA: d.ok = 1'b1;
                OP_LD_B_N, OP_LD_C_N, OP_LD_E_N, OP_LD_L_N, OP_LD_A_N, OP_LD_M_N,
                OP_LDH_N_A, OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_C, OP_CP_N: d.n_imm = 2'd1;
                OP_LD_NN_A, OP_JP: d.n_imm = 2'd2;
                OP_LDI_A_HL, OP_LD_A_DE: d.rd1 = 1'b1;
                OP_LDH_A_N: begin
                    d.n_imm = 2'd1;
                    d.rd1   = 1'b1;
                end
                OP_LD_A_NN: begin
                    d.n_imm = 2'd2;
                    d.rd1   = 1'b1;
                end
                OP_CALL: begin
                    d.n_imm = 2'd2;
                    d.push  = 1'b1;
                end
                OP_RST38, OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: d.push = 1'b1;
                OP_RET, OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: begin
                    d.rd1 = 1'b1;
                    d.rd2 = 1'b1;
                end
                default: d.ok = 1'b0;
            endcase
        end
        return d;
    endfunction

endpackage

/* hw/rtl/sm83x_mem.sv */
module sm83x_mem #(
    parameter int ADDR_BITS = sm83x_pkg::DEF_ADDR_BITS
) (
    input  logic               i_clk,
    input  sm83x_pkg::t_mem_cmd i_cmd,
    output logic [7:0]         o_q
);
    import sm83x_pkg::*;

    logic [7:0] r_mem [2**ADDR_BITS];
    logic [7:0] r_q;
    logic [ADDR_BITS-1:0] addr;

    assign addr = i_cmd.addr[ADDR_BITS-1:0];
    assign o_q  = r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[addr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_q <= r_mem[addr];
        end
    end

endmodule

/* hw/rtl/sm83x_core.sv */
module sm83x_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  sm83x_pkg::t_req     i_req,
    output logic                o_done_valid,
    input  logic                i_done_ready,
    output sm83x_pkg::t_res     o_res,
    output sm83x_pkg::t_mem_cmd o_mem,
    input  logic [7:0]          i_mem_q
);
    import sm83x_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RDA, S_OP, S_IM1, S_IM2, S_ADR, S_D0, S_D1, S_WB, S_PSH, S_FIN
    } t_state;

    t_state      r_state;
    logic [7:0]  r_a, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [3:0]  r_f;
    logic [15:0] r_sp, r_pc;
    logic        r_ime;
    logic [7:0]  r_op, r_i0, r_i1, r_d0, r_d1, r_plo, r_rd;
    logic        r_st;
    t_dec        r_dec;

    logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [3:0]  n_f;
    logic [15:0] n_sp, n_pc;
    logic        n_ime;
    logic        wb_we;
    logic [15:0] wb_addr;
    logic [7:0]  wb_data;
    logic [15:0] push_val;
    logic        set8_en, set16_en;
    logic [2:0]  set8_code;
    logic [1:0]  set16_p;
    logic [7:0]  set8_val, alu_v;
    logic [15:0] set16_val;
    logic        take;
    logic [15:0] hl, de, bc, imm16, rd_addr;
    logic        accept;
    t_dec        dec_q;

    assign hl    = {r_h, r_l};
    assign de    = {r_d, r_e};
    assign bc    = {r_b, r_c};
    assign imm16 = {r_i1, r_i0};
    assign dec_q = f_dec(i_mem_q);

    assign o_req_ready  = (r_state == S_IDLE) || (r_state == S_FIN && i_done_ready);
    assign accept       = i_req_valid && o_req_ready;
    assign o_done_valid = (r_state == S_FIN);

    assign o_res.status    = r_st;
    assign o_res.read_data = r_rd;
    assign o_res.pc_value  = r_pc;
    assign o_res.acc_value = r_a;
    assign o_res.flag_bits = r_f;
    assign o_res.sp_value  = r_sp;

    function automatic logic [7:0] src8(input logic [2:0] code, input logic [7:0] a,
                                        input logic [7:0] b, input logic [7:0] c,
                                        input logic [7:0] d, input logic [7:0] e,
                                        input logic [7:0] h, input logic [7:0] l,
                                        input logic [7:0] m);
        logic [7:0] v;
        unique case (code)
            C8_B:    v = b;
            C8_C:    v = c;
            C8_D:    v = d;
            C8_E:    v = e;
            C8_H:    v = h;
            C8_L:    v = l;
            C8_MEM:  v = m;
            default: v = a;
        endcase
        return v;
    endfunction

    // data address of the read phase
    always_comb begin
        priority if (r_dec.rd2) begin
            rd_addr = r_sp;
        end else if (r_op == OP_LD_A_DE) begin
            rd_addr = de;
        end else if (r_op == OP_LDH_A_N) begin
            rd_addr = {HIGH_PAGE, r_i0};
        end else if (r_op == OP_LD_A_NN) begin
            rd_addr = imm16;
        end else begin
            rd_addr = hl;
        end
    end

    // write-back values
    always_comb begin
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e; n_h = r_h; n_l = r_l;
        n_f = r_f; n_sp = r_sp; n_ime = r_ime;
        n_pc      = r_pc + 16'd1;
        wb_we     = 1'b0;
        wb_addr   = hl;
        wb_data   = r_a;
        push_val  = '0;
        set8_en   = 1'b0;
        set8_code = r_op[5:3];
        set8_val  = '0;
        set16_en  = 1'b0;
        set16_p   = r_op[5:4];
        set16_val = '0;
        alu_v     = '0;
        take      = 1'b0;
        priority if ((r_op & MASK_R8) == PAT_INC8) begin
            alu_v    = src8(r_op[5:3], r_a, r_b, r_c, r_d, r_e, r_h, r_l, r_d0) + 8'd1;
            set8_en  = 1'b1;
            set8_val = alu_v;
            n_f = {alu_v == 8'd0, 1'b0, alu_v[3:0] == 4'h0, r_f[0]};
        end else if ((r_op & MASK_R8) == PAT_DEC8) begin
            alu_v    = src8(r_op[5:3], r_a, r_b, r_c, r_d, r_e, r_h, r_l, r_d0) - 8'd1;
            set8_en  = 1'b1;
            set8_val = alu_v;
            n_f = {alu_v == 8'd0, 1'b1, alu_v[3:0] == 4'hF, r_f[0]};
        end else if ((r_op & MASK_RR) == PAT_INC16 || (r_op & MASK_RR) == PAT_DEC16) begin
            set16_en = 1'b1;
            unique case (r_op[5:4])
                RR_BC:   set16_val = bc;
                RR_DE:   set16_val = de;
                RR_HL:   set16_val = hl;
                default: set16_val = r_sp;
            endcase
            set16_val = r_op[3] ? set16_val - 16'd1 : set16_val + 16'd1;
        end else if ((r_op & MASK_RR) == PAT_LD16) begin
            set16_en  = 1'b1;
            set16_val = imm16;
            n_pc      = r_pc + 16'd3;
        end else if (r_op >= OP_XOR_LO && r_op <= OP_OR_HI) begin
            alu_v = src8(r_op[2:0], r_a, r_b, r_c, r_d, r_e, r_h, r_l, r_d0);
            alu_v = (r_op < OP_OR_LO) ? (r_a ^ alu_v) : (r_a | alu_v);
            n_a   = alu_v;
            n_f   = {alu_v == 8'd0, 3'b000};
        end else if (r_op >= OP_LDAR_LO && r_op <= OP_LDAR_HI) begin
            n_a = src8(r_op[2:0], r_a, r_b, r_c, r_d, r_e, r_h, r_l, r_d0);
        end else begin
            unique case (r_op)
                OP_LD_B_N, OP_LD_C_N, OP_LD_E_N, OP_LD_L_N, OP_LD_A_N, OP_LD_M_N: begin
                    set8_en  = 1'b1;
                    set8_val = r_i0;
                    n_pc     = r_pc + 16'd2;
                end
                OP_LDI_HL_A: begin
                    wb_we = 1'b1;
                    {n_h, n_l} = hl + 16'd1;
                end
                OP_LDD_HL_A: begin
                    wb_we = 1'b1;
                    {n_h, n_l} = hl - 16'd1;
                end
                OP_LD_HL_A: wb_we = 1'b1;
                OP_LD_HL_B: begin
                    wb_we   = 1'b1;
                    wb_data = r_b;
                end
                OP_LDI_A_HL: begin
                    n_a = r_d0;
                    {n_h, n_l} = hl + 16'd1;
                end
                OP_LD_A_DE: n_a = r_d0;
                OP_LDH_A_N: begin
                    n_a  = r_d0;
                    n_pc = r_pc + 16'd2;
                end
                OP_LD_A_NN: begin
                    n_a  = r_d0;
                    n_pc = r_pc + 16'd3;
                end
                OP_LDH_N_A: begin
                    wb_we   = 1'b1;
                    wb_addr = {HIGH_PAGE, r_i0};
                    n_pc    = r_pc + 16'd2;
                end
                OP_LDH_C_A: begin
                    wb_we   = 1'b1;
                    wb_addr = {HIGH_PAGE, r_c};
                end
                OP_LD_NN_A: begin
                    wb_we   = 1'b1;
                    wb_addr = imm16;
                    n_pc    = r_pc + 16'd3;
                end
                OP_LD_C_A: n_c = r_a;
                OP_LD_D_B: n_d = r_b;
                OP_LD_H_B: n_h = r_b;
                OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_C: begin
                    take = (r_op == OP_JR) || (r_op == OP_JR_NZ && !r_f[3]) ||
                           (r_op == OP_JR_Z && r_f[3]) || (r_op == OP_JR_C && r_f[0]);
                    n_pc = r_pc + 16'd2;
                    if (take) begin
                        n_pc = n_pc + {{8{r_i0[7]}}, r_i0};
                    end
                end
                OP_CP_N: begin
                    alu_v = r_a - r_i0;
                    n_f   = {alu_v == 8'd0, 1'b1, r_a[3:0] < r_i0[3:0], r_a < r_i0};
                    n_pc  = r_pc + 16'd2;
                end
                OP_RLCA: begin
                    n_a = {r_a[6:0], r_a[7]};
                    n_f = {3'b000, r_a[7]};
                end
                OP_RLA: begin
                    n_a = {r_a[6:0], r_f[0]};
                    n_f = {3'b000, r_a[7]};
                end
                OP_JP: n_pc = imm16;
                OP_CALL, OP_RST38, OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
                    unique case (r_op)
                        OP_CALL: begin
                            push_val = r_pc + 16'd3;
                            n_pc     = imm16;
                        end
                        OP_RST38: begin
                            push_val = r_pc + 16'd1;
                            n_pc     = RST_VEC;
                        end
                        OP_PUSH_BC: push_val = bc;
                        OP_PUSH_DE: push_val = de;
                        OP_PUSH_HL: push_val = hl;
                        default:    push_val = {r_a, r_f, 4'h0};
                    endcase
                    wb_we   = 1'b1;
                    wb_addr = r_sp - 16'd1;
                    wb_data = push_val[15:8];
                    n_sp    = r_sp - 16'd2;
                end
                OP_RET: begin
                    n_pc = {r_d1, r_d0};
                    n_sp = r_sp + 16'd2;
                end
                OP_POP_BC, OP_POP_DE, OP_POP_HL: begin
                    set16_en  = 1'b1;
                    set16_val = {r_d1, r_d0};
                    n_sp      = r_sp + 16'd2;
                end
                OP_POP_AF: begin
                    n_a  = r_d1;
                    n_f  = r_d0[7:4];
                    n_sp = r_sp + 16'd2;
                end
                OP_DI: n_ime = 1'b0;
                default: n_ime = r_ime;   // NOP, LD B,B
            endcase
        end

        if (set8_en) begin
            unique case (set8_code)
                C8_B: n_b = set8_val;
                C8_C: n_c = set8_val;
                C8_D: n_d = set8_val;
                C8_E: n_e = set8_val;
                C8_H: n_h = set8_val;
                C8_L: n_l = set8_val;
                C8_MEM: begin
                    wb_we   = 1'b1;
                    wb_addr = hl;
                    wb_data = set8_val;
                end
                default: n_a = set8_val;
            endcase
        end
        if (set16_en) begin
            unique case (set16_p)
                RR_BC:   {n_b, n_c} = set16_val;
                RR_DE:   {n_d, n_e} = set16_val;
                RR_HL:   {n_h, n_l} = set16_val;
                default: n_sp = set16_val;
            endcase
        end
    end

    // memory port: one access per cycle
    always_comb begin
        o_mem = '0;
        if (accept) begin
            unique case (i_req.action)
                ACT_WRITE: begin
                    o_mem.we    = 1'b1;
                    o_mem.addr  = i_req.address;
                    o_mem.wdata = i_req.write_data;
                end
                ACT_READ: begin
                    o_mem.re   = 1'b1;
                    o_mem.addr = i_req.address;
                end
                ACT_EXEC: begin
                    o_mem.re   = 1'b1;
                    o_mem.addr = r_pc;
                end
                default: o_mem.re = 1'b0;
            endcase
        end else begin
            unique case (r_state)
                S_OP: begin
                    o_mem.re   = dec_q.ok && (dec_q.n_imm != 2'd0);
                    o_mem.addr = r_pc + 16'd1;
                end
                S_IM1: begin
                    o_mem.re   = (r_dec.n_imm == 2'd2);
                    o_mem.addr = r_pc + 16'd2;
                end
                S_ADR: begin
                    o_mem.re   = r_dec.rd1;
                    o_mem.addr = rd_addr;
                end
                S_D0: begin
                    o_mem.re   = r_dec.rd2;
                    o_mem.addr = r_sp + 16'd1;
                end
                S_WB: begin
                    o_mem.we    = wb_we;
                    o_mem.addr  = wb_addr;
                    o_mem.wdata = wb_data;
                end
                S_PSH: begin
                    o_mem.we    = 1'b1;
                    o_mem.addr  = r_sp;
                    o_mem.wdata = r_plo;
                end
                default: o_mem.re = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0;
            r_e <= '0; r_h <= '0; r_l <= '0;
            r_f <= '0; r_sp <= '0; r_pc <= '0; r_ime <= 1'b0;
            r_st <= ST_DONE;
            r_rd <= '0;
        end else if (accept) begin
            r_rd <= '0;
            r_st <= ST_DONE;
            unique case (i_req.action)
                ACT_WRITE: r_state <= S_FIN;
                ACT_READ:  r_state <= S_RDA;
                ACT_EXEC:  r_state <= S_OP;
                default: begin
                    r_st    <= ST_UNSUP;
                    r_state <= S_FIN;
                end
            endcase
        end else begin
            unique case (r_state)
                S_IDLE: r_state <= S_IDLE;
                S_RDA: begin
                    r_rd    <= i_mem_q;
                    r_state <= S_FIN;
                end
                S_OP: begin
                    r_op  <= i_mem_q;
                    r_dec <= dec_q;
                    priority if (!dec_q.ok) begin
                        r_st    <= ST_UNSUP;
                        r_state <= S_FIN;
                    end else if (dec_q.n_imm != 2'd0) begin
                        r_state <= S_IM1;
                    end else begin
                        r_state <= S_ADR;
                    end
                end
                S_IM1: begin
                    r_i0    <= i_mem_q;
                    r_state <= (r_dec.n_imm == 2'd2) ? S_IM2 : S_ADR;
                end
                S_IM2: begin
                    r_i1    <= i_mem_q;
                    r_state <= S_ADR;
                end
                S_ADR: r_state <= r_dec.rd1 ? S_D0 : S_WB;
                S_D0: begin
                    r_d0    <= i_mem_q;
                    r_state <= r_dec.rd2 ? S_D1 : S_WB;
                end
                S_D1: begin
                    r_d1    <= i_mem_q;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
                    r_e <= n_e; r_h <= n_h; r_l <= n_l;
                    r_f <= n_f; r_sp <= n_sp; r_pc <= n_pc; r_ime <= n_ime;
                    r_plo   <= push_val[7:0];
                    r_state <= r_dec.push ? S_PSH : S_FIN;
                end
                S_PSH: r_state <= S_FIN;
                S_FIN: begin
                    if (i_done_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/sm83_instruction_subset_executor.sv */
// SM83 subset executor: a small core with its own byte memory, registers,
// SP, PC and interrupt enable.
// Input channel (i_valid/o_ready, i_req): one request is a memory byte
// write, a memory byte read, or the execution of the instruction at PC.
// Output channel (o_valid/i_ready, o_res): exactly one result per request,
// in order: status, read byte, and PC, A, flags, SP after the request.
// After accept a write goes straight to the result, a read first passes
// the read-data state, and an execute fetches the opcode and immediate
// bytes, reads any data or stack bytes (two for POP/RET), writes back and,
// for pushes, writes the second stack byte. One memory port carries every
// fetch, data and stack byte; a new request waits until the last is done.
// A finished result is held in an output register, so the core takes the
// next request while the receiver stalls; if the output register is still
// full when the following result is ready, the core holds that result and
// stops accepting until the register drains.
// Reset (synchronous, active low) clears registers, flags, SP, PC and IME;
// memory contents are undefined until written. Unsupported opcodes return
// status 1 and change nothing.
module sm83_instruction_subset_executor #(
    parameter int ADDR_BITS = sm83x_pkg::DEF_ADDR_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sm83x_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output sm83x_pkg::t_res o_res
);
    import sm83x_pkg::*;

    t_mem_cmd mem_cmd;
    logic [7:0] mem_q;
    logic done_valid, done_ready;
    t_res done_res;

    logic r_valid;
    t_res r_res;

    sm83x_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
        .i_clk (i_clk),
        .i_cmd (mem_cmd),
        .o_q   (mem_q)
    );

    sm83x_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .o_req_ready  (o_ready),
        .i_req        (i_req),
        .o_done_valid (done_valid),
        .i_done_ready (done_ready),
        .o_res        (done_res),
        .o_mem        (mem_cmd),
        .i_mem_q      (mem_q)
    );

    // output register: free when empty or being taken this cycle
    assign done_ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (done_ready) begin
            r_valid <= done_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_ready && done_valid) begin
            r_res <= done_res;
        end
    end

endmodule

/* tb/tb_sm83_instruction_subset_executor.sv */
module tb_sm83_instruction_subset_executor;
    timeunit 1ns;
    timeprecision 1ps;

    import sm83x_pkg::*;

    localparam int N_ITEMS   = 950;
    localparam int CYC_LIMIT = 200000;
    localparam int HOLD_AT   = 400;   // results taken before the long receiver hold-off
    localparam int HOLD_LEN  = 300;

    // one queued request with its predicted result
    typedef struct {
        t_req req;
        t_res res;
        bit   drain;   // sender waits for all results before offering this one
    } t_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req   = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_res o_res;

    sm83_instruction_subset_executor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Core model state: register file indexed by operand code (A at 7,
    // code 6 is the (HL) slot and never used), flags {Z,N,H,C}.
    // ------------------------------------------------------------------
    logic [7:0]  core_mem [65536];
    bit          wrote [65536];      // byte has been written at least once
    logic [15:0] wrote_list [$];     // written addresses, for legal reads
    logic [7:0]  rf [8];
    logic [3:0]  fl;
    logic [15:0] sp_r;
    logic [15:0] pc_r;
    logic        ime_r;

    function automatic void mem_put(logic [15:0] a, logic [7:0] v);
        core_mem[a] = v;
        if (!wrote[a]) begin
            wrote[a] = 1'b1;
            wrote_list.push_back(a);
        end
    endfunction

    function automatic logic [7:0] r8(logic [2:0] c);
        if (c == C8_MEM) return core_mem[{rf[C8_H], rf[C8_L]}];
        return rf[c];
    endfunction

    function automatic void r8_put(logic [2:0] c, logic [7:0] v);
        if (c == C8_MEM) mem_put({rf[C8_H], rf[C8_L]}, v);
        else rf[c] = v;
    endfunction

    function automatic logic [15:0] rr(logic [1:0] p);
        case (p)
            RR_BC:   return {rf[C8_B], rf[C8_C]};
            RR_DE:   return {rf[C8_D], rf[C8_E]};
            RR_HL:   return {rf[C8_H], rf[C8_L]};
            default: return sp_r;
        endcase
    endfunction

    function automatic void rr_put(logic [1:0] p, logic [15:0] v);
        case (p)
            RR_BC:   {rf[C8_B], rf[C8_C]} = v;
            RR_DE:   {rf[C8_D], rf[C8_E]} = v;
            RR_HL:   {rf[C8_H], rf[C8_L]} = v;
            default: sp_r = v;
        endcase
    endfunction

    function automatic void push16(logic [15:0] v);
        sp_r = sp_r - 16'd1;
        mem_put(sp_r, v[15:8]);
        sp_r = sp_r - 16'd1;
        mem_put(sp_r, v[7:0]);
    endfunction

    function automatic logic [15:0] pop16();
        logic [7:0] lo;
        lo   = core_mem[sp_r];
        sp_r = sp_r + 16'd1;
        pop16 = {core_mem[sp_r], lo};
        sp_r = sp_r + 16'd1;
    endfunction

    // runs the instruction at PC, returns the status
    function automatic logic run_insn();
        logic [15:0] pc, nxt, hl, w, i16;
        logic [7:0]  op, i8, a, v;
        logic        tk;
        pc  = pc_r;
        op  = core_mem[pc];
        i8  = core_mem[pc + 16'd1];
        i16 = {core_mem[pc + 16'd2], i8};
        nxt = pc + 16'd1;
        hl  = rr(RR_HL);
        a   = rf[C8_A];
        if ((op & MASK_R8) == PAT_INC8) begin
            v = r8(op[5:3]) + 8'd1;
            r8_put(op[5:3], v);
            fl = {v == 8'd0, 1'b0, v[3:0] == 4'h0, fl[0]};
        end else if ((op & MASK_R8) == PAT_DEC8) begin
            v = r8(op[5:3]) - 8'd1;
            r8_put(op[5:3], v);
            fl = {v == 8'd0, 1'b1, v[3:0] == 4'hF, fl[0]};
        end else if ((op & MASK_RR) == PAT_INC16) begin
            rr_put(op[5:4], rr(op[5:4]) + 16'd1);
        end else if ((op & MASK_RR) == PAT_DEC16) begin
            rr_put(op[5:4], rr(op[5:4]) - 16'd1);
        end else if ((op & MASK_RR) == PAT_LD16) begin
            rr_put(op[5:4], i16);
            nxt = pc + 16'd3;
        end else if (op >= OP_XOR_LO && op <= OP_OR_HI) begin
            v = (op < OP_OR_LO) ? (a ^ r8(op[2:0])) : (a | r8(op[2:0]));
            rf[C8_A] = v;
            fl = {v == 8'd0, 3'b000};
        end else if (op >= OP_LDAR_LO && op <= OP_LDAR_HI) begin
            rf[C8_A] = r8(op[2:0]);
        end else begin
            case (op)
                OP_NOP, OP_LD_B_B: ;
                OP_LD_B_N, OP_LD_C_N, OP_LD_E_N, OP_LD_L_N, OP_LD_A_N, OP_LD_M_N: begin
                    r8_put(op[5:3], i8);
                    nxt = pc + 16'd2;
                end
                OP_LDI_HL_A: begin mem_put(hl, a); rr_put(RR_HL, hl + 16'd1); end
                OP_LDD_HL_A: begin mem_put(hl, a); rr_put(RR_HL, hl - 16'd1); end
                OP_LD_HL_A:  mem_put(hl, a);
                OP_LD_HL_B:  mem_put(hl, rf[C8_B]);
                OP_LDI_A_HL: begin rf[C8_A] = core_mem[hl]; rr_put(RR_HL, hl + 16'd1); end
                OP_LD_A_DE:  rf[C8_A] = core_mem[rr(RR_DE)];
                OP_LDH_N_A:  begin mem_put({HIGH_PAGE, i8}, a); nxt = pc + 16'd2; end
                OP_LDH_A_N:  begin rf[C8_A] = core_mem[{HIGH_PAGE, i8}]; nxt = pc + 16'd2; end
                OP_LDH_C_A:  mem_put({HIGH_PAGE, rf[C8_C]}, a);
                OP_LD_NN_A:  begin mem_put(i16, a); nxt = pc + 16'd3; end
                OP_LD_A_NN:  begin rf[C8_A] = core_mem[i16]; nxt = pc + 16'd3; end
                OP_LD_C_A:   rf[C8_C] = a;
                OP_LD_D_B:   rf[C8_D] = rf[C8_B];
                OP_LD_H_B:   rf[C8_H] = rf[C8_B];
                OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_C: begin
                    tk = (op == OP_JR) || (op == OP_JR_NZ && !fl[3]) ||
                         (op == OP_JR_Z && fl[3]) || (op == OP_JR_C && fl[0]);
                    nxt = pc + 16'd2;
                    if (tk) nxt = nxt + {{8{i8[7]}}, i8};
                end
                OP_CP_N: begin
                    v  = a - i8;
                    fl = {v == 8'd0, 1'b1, a[3:0] < i8[3:0], a < i8};
                    nxt = pc + 16'd2;
                end
                OP_RLCA: begin rf[C8_A] = {a[6:0], a[7]}; fl = {3'b000, a[7]}; end
                OP_RLA:  begin rf[C8_A] = {a[6:0], fl[0]}; fl = {3'b000, a[7]}; end
                OP_JP:   nxt = i16;
                OP_CALL: begin push16(pc + 16'd3); nxt = i16; end
                OP_RET:  nxt = pop16();
                OP_RST38: begin push16(pc + 16'd1); nxt = RST_VEC; end
                OP_DI:   ime_r = 1'b0;
                OP_PUSH_BC: push16(rr(RR_BC));
                OP_PUSH_DE: push16(rr(RR_DE));
                OP_PUSH_HL: push16(hl);
                OP_PUSH_AF: push16({a, fl, 4'h0});
                OP_POP_BC:  rr_put(RR_BC, pop16());
                OP_POP_DE:  rr_put(RR_DE, pop16());
                OP_POP_HL:  rr_put(RR_HL, pop16());
                OP_POP_AF: begin
                    w = pop16();
                    rf[C8_A] = w[15:8];
                    fl = w[7:4];
                end
                default: return ST_UNSUP;
            endcase
        end
        pc_r = nxt;
        return ST_DONE;
    endfunction

    // applies one request to the model state and returns its result
    function automatic t_res step_core(t_req q);
        t_res r;
        r = '0;
        r.status = ST_DONE;
        case (q.action)
            ACT_WRITE: mem_put(q.address, q.write_data);
            ACT_READ:  r.read_data = core_mem[q.address];
            ACT_EXEC:  r.status = run_insn();
            default:   r.status = ST_UNSUP;
        endcase
        r.pc_value  = pc_r;
        r.acc_value = rf[C8_A];
        r.flag_bits = fl;
        r.sp_value  = sp_r;
        return r;
    endfunction

    function automatic bit op_known(logic [7:0] op);
        return ((op & MASK_R8) == PAT_INC8) || ((op & MASK_R8) == PAT_DEC8) ||
               ((op & MASK_RR) == PAT_INC16) || ((op & MASK_RR) == PAT_DEC16) ||
               ((op & MASK_RR) == PAT_LD16) ||
               (op >= OP_XOR_LO && op <= OP_OR_HI) ||
               (op >= OP_LDAR_LO && op <= OP_LDAR_HI) ||
               (op inside {OP_NOP, OP_LD_B_B, OP_LD_B_N, OP_LD_C_N, OP_LD_E_N, OP_LD_L_N,
                           OP_LD_A_N, OP_LD_M_N, OP_LDI_HL_A, OP_LDD_HL_A, OP_LD_HL_A,
                           OP_LD_HL_B, OP_LDI_A_HL, OP_LD_A_DE, OP_LDH_N_A, OP_LDH_A_N,
                           OP_LDH_C_A, OP_LD_NN_A, OP_LD_A_NN, OP_LD_C_A, OP_LD_D_B,
                           OP_LD_H_B, OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_C, OP_CP_N,
                           OP_RLCA, OP_RLA, OP_JP, OP_CALL, OP_RET, OP_RST38, OP_DI,
                           OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF, OP_POP_BC,
                           OP_POP_DE, OP_POP_HL, OP_POP_AF});
    endfunction

    // bytes the core fetches for an opcode
    function automatic int op_len(logic [7:0] op);
        if (!op_known(op)) return 1;
        if ((op & MASK_RR) == PAT_LD16 ||
            op inside {OP_LD_NN_A, OP_LD_A_NN, OP_JP, OP_CALL}) return 3;
        if (op inside {OP_LD_B_N, OP_LD_C_N, OP_LD_E_N, OP_LD_L_N, OP_LD_A_N, OP_LD_M_N,
                       OP_LDH_N_A, OP_LDH_A_N, OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_C,
                       OP_CP_N}) return 2;
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus queue and result store
    // ------------------------------------------------------------------
    t_item req_q [$];
    t_res  due_q [$];    // predicted results of accepted requests, oldest first
    bit    drain_next;

    task automatic send(t_act act, logic [15:0] ad, logic [7:0] d);
        t_item it;
        it.req.action     = act;
        it.req.address    = ad;
        it.req.write_data = d;
        it.res   = step_core(it.req);
        it.drain = drain_next;
        drain_next = 1'b0;
        req_q.push_back(it);
    endtask

    // Places one instruction at PC and runs it. Every byte the core will
    // read (operands, stack words, fetch bytes) is written first if unknown.
    task automatic run_op(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
        logic [15:0] need [$];
        logic [15:0] hl;
        logic [15:0] fa;
        logic [7:0]  val;
        int          len;
        len = op_len(op);
        hl  = rr(RR_HL);
        if (((op & MASK_R8) == PAT_INC8 || (op & MASK_R8) == PAT_DEC8) && op[5:3] == C8_MEM)
            need.push_back(hl);
        if (op >= OP_XOR_LO && op <= OP_OR_HI && op[2:0] == C8_MEM)
            need.push_back(hl);
        case (op)
            OP_LDI_A_HL: need.push_back(hl);
            OP_LD_A_DE:  need.push_back(rr(RR_DE));
            OP_LDH_A_N:  need.push_back({HIGH_PAGE, b1});
            OP_LD_A_NN:  need.push_back({b2, b1});
            OP_RET, OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: begin
                need.push_back(sp_r);
                need.push_back(sp_r + 16'd1);
            end
            default: ;
        endcase
        foreach (need[k])
            if (!wrote[need[k]]) send(ACT_WRITE, need[k], 8'($urandom_range(0, 255)));
        for (int k = 0; k < len; k++) begin
            val = (k == 0) ? op : (k == 1) ? b1 : b2;
            fa  = pc_r + 16'(k);
            if (!wrote[fa] || core_mem[fa] != val)
                send(ACT_WRITE, fa, val);
        end
        send(ACT_EXEC, 16'($urandom), 8'($urandom));
    endtask

    task automatic gen_stimulus();
        logic [7:0] op, b1, b2;
        int         dice;
        // field extremes and the unused action code
        send(ACT_WRITE, 16'hFFFF, 8'hFF);
        send(ACT_WRITE, 16'h0000, 8'h00);
        send(ACT_READ,  16'hFFFF, 8'h00);
        send(ACT_READ,  16'h0000, 8'hFF);
        send(ACT_NONE,  16'hFFFF, 8'hFF);
        // half carry on INC and DEC across a nibble
        run_op(OP_LD_A_N, 8'h0F, 8'h00);
        run_op(8'h3C, 8'h00, 8'h00);              // INC A
        run_op(8'h3D, 8'h00, 8'h00);              // DEC A
        // XOR with the byte at HL
        run_op(8'h21, 8'h00, 8'h80);              // LD HL,8000h
        run_op(8'hAE, 8'h00, 8'h00);              // XOR (HL)
        // CP against F0h, which sets carry when it borrows
        run_op(OP_CP_N, 8'hF0, 8'h00);
        // backward relative jump, then RST and its return address on the stack
        run_op(OP_JR, 8'hF0, 8'h00);
        run_op(OP_RST38, 8'h00, 8'h00);
        run_op(OP_RET, 8'h00, 8'h00);
        // flag nibble through the stack
        run_op(OP_PUSH_AF, 8'h00, 8'h00);
        run_op(OP_POP_AF, 8'h00, 8'h00);
        // CB prefix is not supported
        run_op(8'hCB, 8'h00, 8'h00);

        while (req_q.size() < N_ITEMS) begin
            if (req_q.size() > N_ITEMS / 2 && req_q.size() < N_ITEMS / 2 + 4)
                drain_next = 1'b1;
            dice = $urandom_range(0, 99);
            if (dice < 6) begin
                send(ACT_WRITE, 16'($urandom), 8'($urandom));
            end else if (dice < 12) begin
                send(ACT_READ, wrote_list[$urandom_range(0, wrote_list.size() - 1)],
                     8'($urandom));
            end else if (dice < 14) begin
                send(ACT_NONE, 16'($urandom), 8'($urandom));
            end else begin
                b1 = 8'($urandom);
                b2 = 8'($urandom);
                if (dice < 40 && wrote[pc_r]) begin
                    // fall through into whatever sits at PC already
                    op = core_mem[pc_r];
                    if (wrote[pc_r + 16'd1]) b1 = core_mem[pc_r + 16'd1];
                    if (wrote[pc_r + 16'd2]) b2 = core_mem[pc_r + 16'd2];
                end else if (dice < 48) begin
                    op = 8'($urandom);
                end else begin
                    do op = 8'($urandom); while (!op_known(op));
                end
                run_op(op, b1, b2);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge: request accept, result check, timeout
    // ------------------------------------------------------------------
    int   n_sent, n_acc, n_got, n_err, cycles;
    t_res cur_res;

    task automatic chk(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && o_ready) begin
                due_q.push_back(cur_res);
                n_acc++;
            end
            if (o_valid && i_ready) begin
                n_got++;
                if (due_q.size() == 0) begin
                    $error("result with no request outstanding");
                    n_err++;
                end else begin
                    e = due_q.pop_front();
                    chk("status",    e.status,    o_res.status);
                    chk("read_data", e.read_data, o_res.read_data);
                    chk("pc_value",  e.pc_value,  o_res.pc_value);
                    chk("acc_value", e.acc_value, o_res.acc_value);
                    chk("flag_bits", e.flag_bits, o_res.flag_bits);
                    chk("sp_value",  e.sp_value,  o_res.sp_value);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver (falling edge). Random gaps between requests, with
    // a gap-free stretch every 128 requests; a marked request waits for the
    // pipe to drain completely.
    // ------------------------------------------------------------------
    int snd_gap;

    always @(negedge i_clk) begin
        t_item it;
        logic  nv;
        if (i_rst_n && !(i_valid && n_acc != n_sent)) begin
            nv = 1'b0;
            if (i_valid) snd_gap = (n_sent % 128 < 96) ? $urandom_range(0, 3) : 0;
            if (snd_gap > 0) begin
                snd_gap--;
            end else if (req_q.size() > 0 && !(req_q[0].drain && due_q.size() != 0)) begin
                it      = req_q.pop_front();
                cur_res = it.res;
                i_req  <= it.req;
                nv      = 1'b1;
                n_sent++;
            end
            i_valid <= nv;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver (falling edge). Random stall after each result,
    // no stalls in part of every 100, and one long hold-off so the output
    // register fills and the core stops taking requests.
    // ------------------------------------------------------------------
    int rcv_seen, rcv_gap, rcv_hold;
    bit held_once;

    always @(negedge i_clk) begin
        logic rdy;
        if (i_rst_n) begin
            if (n_got != rcv_seen) begin
                rcv_seen = n_got;
                rcv_gap  = (n_got % 100 < 70) ? $urandom_range(0, 3) : 0;
                if (!held_once && n_got >= HOLD_AT) begin
                    held_once = 1'b1;
                    rcv_hold  = HOLD_LEN;
                end
            end
            if (rcv_hold > 0) begin
                rcv_hold--;
                rdy = 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Reset, stimulus build, end of run
    // ------------------------------------------------------------------
    initial begin
        foreach (rf[k]) rf[k] = 8'h00;
        fl    = 4'h0;
        sp_r  = 16'h0000;
        pc_r  = 16'h0000;
        ime_r = 1'b0;
        gen_stimulus();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (req_q.size() != 0 || n_acc != n_sent || due_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
